// ===== sv/scp_pkg.sv =====
// Shared types and command codes for the serial commanded positioner.
`timescale 1ns / 1ps

package scp_pkg;

  localparam int unsigned OPERAND_BITS  = 16;
  localparam int unsigned DEADBAND_BITS = 15;
  localparam int unsigned OUT_POS_BITS  = 16;

  localparam logic [7:0] CMD_SET_TARGET   = 8'b1000_0100;
  localparam logic [7:0] CMD_SET_POSITION = 8'b1000_0011;
  localparam logic [7:0] CMD_HOME_START   = 8'b0000_0111;
  localparam logic [7:0] CMD_HOME_ABORT   = 8'b0000_1000;
  localparam logic [7:0] CMD_LED_ON       = 8'b0000_0110;
  localparam logic [7:0] CMD_LED_OFF      = 8'b0000_0101;
  localparam logic [7:0] CMD_OPERAND_FLAG = 8'b1000_0000;
  localparam logic [7:0] CMD_NONE         = 8'h00;

  localparam logic [DEADBAND_BITS-1:0] DEADBAND_RESET = 15'd2;

  typedef enum logic [1:0] {
    OP_IDLE = 2'd0,
    OP_BYTE = 2'd1,
    OP_STEP = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    PH_CMD  = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    DIR_STOP    = 2'd0,
    DIR_EXTEND  = 2'd1,
    DIR_RETRACT = 2'd2
  } dir_t;

  // Actions the parser requests for one byte
  typedef struct packed {
    logic set_target;
    logic set_position;
    logic home_start;
    logic home_abort;
    logic led_on;
    logic led_off;
    logic err_clear;
    logic err_set;
  } cmd_act_t;

endpackage

// ===== sv/scp_parser.sv =====
// Serial command parser: next parse state and decoded actions for one byte.
`timescale 1ns / 1ps

module scp_parser import scp_pkg::*; (
  input  logic                    byte_en,
  input  logic [7:0]              rx_byte,
  input  phase_t                  phase,
  input  logic [7:0]              pending,
  input  logic [OPERAND_BITS-1:0] operand,
  output phase_t                  phase_next,
  output logic [7:0]              pending_next,
  output logic [OPERAND_BITS-1:0] operand_next,
  output logic [OPERAND_BITS-1:0] operand_value,
  output cmd_act_t                act
);

  assign operand_value = {operand[15:8], rx_byte};

  always_comb begin
    phase_next   = phase;
    pending_next = pending;
    operand_next = operand;
    act          = '0;
    if (byte_en) begin
      case (phase)
        PH_HIGH: begin
          operand_next = {rx_byte, 8'h00};
          phase_next   = PH_LOW;
        end
        PH_LOW: begin
          act.set_target   = (pending == CMD_SET_TARGET);
          act.set_position = (pending == CMD_SET_POSITION);
          pending_next     = CMD_NONE;
          operand_next     = '0;
          phase_next       = PH_CMD;
        end
        default: begin
          phase_next = PH_CMD;
          if (rx_byte != CMD_NONE) begin
            act.err_clear = 1'b1;
            if ((rx_byte & CMD_OPERAND_FLAG) != CMD_NONE) begin
              pending_next = rx_byte;
              operand_next = '0;
              phase_next   = PH_HIGH;
            end else begin
              case (rx_byte)
                CMD_HOME_START: act.home_start = 1'b1;
                CMD_HOME_ABORT: act.home_abort = 1'b1;
                CMD_LED_ON:     act.led_on     = 1'b1;
                CMD_LED_OFF:    act.led_off    = 1'b1;
                default:        act.err_set    = 1'b1;
              endcase
            end
          end
        end
      endcase
    end
  end

endmodule

// ===== sv/scp_drive.sv =====
// Drive decision: deadband compare, homing override and switch handling.
`timescale 1ns / 1ps

module scp_drive import scp_pkg::*; #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic [POSITION_BITS-1:0] position,
  input  logic [POSITION_BITS-1:0] target,
  input  logic                     homing,
  input  logic [DEADBAND_BITS-1:0] deadband,
  input  logic                     home_switch_n,
  input  logic                     limit_switch_n,
  output dir_t                     dir,
  output logic                     home_hit
);

  // two spare bits so p - d and p + d never overflow
  localparam int unsigned MW = (POSITION_BITS > DEADBAND_BITS) ? POSITION_BITS : DEADBAND_BITS;
  localparam int unsigned CW = MW + 2;

  logic signed [CW-1:0] p;
  logic signed [CW-1:0] t;
  logic signed [CW-1:0] d;
  dir_t                 raw_dir;

  assign p = CW'(signed'(position));
  assign t = CW'(signed'(target));
  assign d = signed'(CW'(deadband));

  always_comb begin
    if (homing) begin
      raw_dir = DIR_RETRACT;
    end else if (p - d > t) begin
      raw_dir = DIR_RETRACT;
    end else if (p + d < t) begin
      raw_dir = DIR_EXTEND;
    end else begin
      raw_dir = DIR_STOP;
    end

    home_hit = !home_switch_n && (raw_dir == DIR_RETRACT);
    dir      = raw_dir;
    if (home_hit) begin
      dir = DIR_STOP;
    end
    if (!limit_switch_n && (raw_dir == DIR_EXTEND)) begin
      dir = DIR_STOP;
    end
  end

endmodule

// ===== sv/serial_commanded_positioner_top.sv =====
// Top level of the serial commanded positioner: state, result register, config.
`timescale 1ns / 1ps

// Takes one item per clock while in_ready is high. Each accepted item (idle
// tick, serial byte or encoder step plus switch levels) updates parser and
// position state in the cycle it is accepted, and its result appears in the
// output register on the next cycle. in_ready is low in reset and otherwise
// drops only while that output register holds a result that has not been
// taken; a result taken in the same cycle frees the slot. The deadband
// register is written through the cfg port, ready whenever reset is low, and
// should only be changed while no result is outstanding.
module serial_commanded_positioner_top import scp_pkg::*; #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [DEADBAND_BITS-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               op,
  input  logic [7:0]               rx_byte,
  input  logic                     step_down,
  input  logic                     home_switch_n,
  input  logic                     limit_switch_n,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     extend_drive,
  output logic                     retract_drive,
  output logic                     led_user,
  output logic                     led_error,
  output logic                     led_homing,
  output logic signed [OUT_POS_BITS-1:0] current_position
);

  logic [DEADBAND_BITS-1:0] deadband;
  logic [POSITION_BITS-1:0] position_count;
  logic [POSITION_BITS-1:0] target_position;
  logic                     homing_active;
  logic [7:0]               pending_command;
  logic [OPERAND_BITS-1:0]  operand_word;
  phase_t                   parse_phase;
  logic                     user_led;
  logic                     error_led;

  logic [POSITION_BITS-1:0] position_count_next;
  logic [POSITION_BITS-1:0] target_position_next;
  logic                     homing_active_next;
  logic [7:0]               pending_command_next;
  logic [OPERAND_BITS-1:0]  operand_word_next;
  phase_t                   parse_phase_next;
  logic                     user_led_next;
  logic                     error_led_next;

  logic                     accept;
  logic                     byte_en;
  logic [OPERAND_BITS-1:0]  operand_value;
  logic signed [31:0]       operand_ext;
  logic [POSITION_BITS-1:0] operand_pos;
  logic [POSITION_BITS-1:0] pos_evt;
  logic [POSITION_BITS-1:0] tgt_evt;
  logic                     homing_evt;
  logic [31:0]              pos_wide;
  cmd_act_t                 act;
  dir_t                     dir;
  logic                     home_hit;

  assign cfg_ready = !rst;
  assign in_ready  = !rst && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;
  assign byte_en   = (op == OP_BYTE);

  scp_parser u_parser (
    .byte_en       (byte_en),
    .rx_byte       (rx_byte),
    .phase         (parse_phase),
    .pending       (pending_command),
    .operand       (operand_word),
    .phase_next    (parse_phase_next),
    .pending_next  (pending_command_next),
    .operand_next  (operand_word_next),
    .operand_value (operand_value),
    .act           (act)
  );

  // operand is signed 16 bits, fitted to the position width
  assign operand_ext = 32'(signed'(operand_value));
  assign operand_pos = operand_ext[POSITION_BITS-1:0];

  always_comb begin
    pos_evt    = position_count;
    tgt_evt    = target_position;
    homing_evt = homing_active;
    if (op == OP_STEP) begin
      pos_evt = step_down ? position_count - 1'b1 : position_count + 1'b1;
    end
    if (act.set_position) pos_evt = operand_pos;
    if (act.set_target)   tgt_evt = operand_pos;
    if (act.home_start)   homing_evt = 1'b1;
    if (act.home_abort)   homing_evt = 1'b0;

    user_led_next = user_led;
    if (act.led_on)  user_led_next = 1'b1;
    if (act.led_off) user_led_next = 1'b0;

    error_led_next = error_led;
    if (act.err_clear) error_led_next = 1'b0;
    if (act.err_set)   error_led_next = 1'b1;
  end

  scp_drive #(
    .POSITION_BITS (POSITION_BITS)
  ) u_drive (
    .position       (pos_evt),
    .target         (tgt_evt),
    .homing         (homing_evt),
    .deadband       (deadband),
    .home_switch_n  (home_switch_n),
    .limit_switch_n (limit_switch_n),
    .dir            (dir),
    .home_hit       (home_hit)
  );

  // reaching home zeroes the frame
  assign position_count_next  = home_hit ? '0 : pos_evt;
  assign target_position_next = home_hit ? '0 : tgt_evt;
  assign homing_active_next   = home_hit ? 1'b0 : homing_evt;
  assign pos_wide             = 32'(position_count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband <= DEADBAND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      deadband <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count  <= '0;
      target_position <= '0;
      homing_active   <= 1'b0;
      pending_command <= CMD_NONE;
      operand_word    <= '0;
      parse_phase     <= PH_CMD;
      user_led        <= 1'b0;
      error_led       <= 1'b1;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        position_count  <= position_count_next;
        target_position <= target_position_next;
        homing_active   <= homing_active_next;
        pending_command <= pending_command_next;
        operand_word    <= operand_word_next;
        parse_phase     <= parse_phase_next;
        user_led        <= user_led_next;
        error_led       <= error_led_next;
      end
      out_valid <= accept || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      extend_drive     <= (dir == DIR_EXTEND);
      retract_drive    <= (dir == DIR_RETRACT);
      led_user         <= user_led_next;
      led_error        <= error_led_next;
      led_homing       <= homing_active_next;
      current_position <= signed'(pos_wide[OUT_POS_BITS-1:0]);
    end
  end

endmodule

// ===== sv/scp_checker.sv =====
// Port-level checks for the serial commanded positioner, bound to the top.
`timescale 1ns / 1ps

module scp_checker import scp_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     extend_drive,
  input logic                     retract_drive,
  input logic                     led_user,
  input logic                     led_error,
  input logic                     led_homing,
  input logic signed [OUT_POS_BITS-1:0] current_position
);

  // an accepted item always leaves a result behind
  a_item_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  // an empty output stage never blocks input
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  a_one_direction: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(extend_drive && retract_drive))
    else $error("extend and retract both driven");

  // homing always retracts unless home was reached, which ends homing
  a_homing_retracts: assert property (@(posedge clk) disable iff (rst)
    out_valid && led_homing |-> retract_drive)
    else $error("homing result without retract");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(current_position)
      && $stable(led_error) && $stable(led_user))
    else $error("stalled result changed");

endmodule

bind serial_commanded_positioner_top scp_checker u_scp_checker (.*);

// ===== sim/tb.sv =====
// Testbench for serial_commanded_positioner_top: predicts each result, checks each field.
`timescale 1ns / 1ps

import scp_pkg::*;

typedef struct packed {
  logic [1:0] op;
  logic [7:0] rx_byte;
  logic       step_down;
  logic       home_n;
  logic       limit_n;
} pos_item_t;

typedef struct packed {
  logic                    extend;
  logic                    retract;
  logic                    led_user;
  logic                    led_error;
  logic                    led_homing;
  logic [OUT_POS_BITS-1:0] position;
} pos_result_t;

class positioner_checker;
  logic [DEADBAND_BITS-1:0] deadband;
  logic [OUT_POS_BITS-1:0]  position;
  logic [OUT_POS_BITS-1:0]  target;
  logic                     homing;
  logic                     user_led;
  logic                     error_led;
  logic [7:0]               pending_cmd;
  logic [OPERAND_BITS-1:0]  operand;
  phase_t                   parse_state;
  dir_t                     dir;
  pos_result_t              expected_outputs[$];
  int                       failures;

  function new();
    deadband    = DEADBAND_RESET;
    position    = '0;
    target      = '0;
    homing      = 1'b0;
    user_led    = 1'b0;
    error_led   = 1'b1;
    pending_cmd = CMD_NONE;
    operand     = '0;
    parse_state = PH_CMD;
    dir         = DIR_STOP;
    failures    = 0;
  endfunction

  function void set_deadband(logic [DEADBAND_BITS-1:0] value);
    deadband = value;
  endfunction

  function int outstanding();
    return expected_outputs.size();
  endfunction

  function void parse_byte(logic [7:0] b);
    case (parse_state)
      PH_HIGH: begin
        operand     = {b, 8'h00};
        parse_state = PH_LOW;
      end
      PH_LOW: begin
        operand = {operand[15:8], b};
        // operand is already 16-bit two's complement, same width as position
        if (pending_cmd == CMD_SET_TARGET)
          target = operand;
        else if (pending_cmd == CMD_SET_POSITION)
          position = operand;
        pending_cmd = CMD_NONE;
        operand     = '0;
        parse_state = PH_CMD;
      end
      default: begin
        parse_state = PH_CMD;
        if (b != CMD_NONE) begin
          error_led = 1'b0;
          if ((b & CMD_OPERAND_FLAG) != CMD_NONE) begin
            pending_cmd = b;
            operand     = '0;
            parse_state = PH_HIGH;
          end else if (b == CMD_HOME_START) begin
            homing = 1'b1;
          end else if (b == CMD_HOME_ABORT) begin
            homing = 1'b0;
          end else if (b == CMD_LED_ON) begin
            user_led = 1'b1;
          end else if (b == CMD_LED_OFF) begin
            user_led = 1'b0;
          end else begin
            error_led = 1'b1;
          end
        end
      end
    endcase
  endfunction

  function void note_item(pos_item_t it);
    int          p;
    int          t;
    int          d;
    pos_result_t r;
    if (it.op == OP_BYTE)
      parse_byte(it.rx_byte);
    else if (it.op == OP_STEP)
      position = it.step_down ? position - 1'b1 : position + 1'b1;

    if (homing) begin
      dir = DIR_RETRACT;
    end else begin
      // compare on sign-extended values so it never wraps
      p = int'($signed(position));
      t = int'($signed(target));
      d = int'(deadband);
      if (p - d > t)
        dir = DIR_RETRACT;
      else if (p + d < t)
        dir = DIR_EXTEND;
      else
        dir = DIR_STOP;
    end
    if (!it.home_n && dir == DIR_RETRACT) begin
      dir      = DIR_STOP;
      position = '0;
      target   = '0;
      homing   = 1'b0;
    end
    if (!it.limit_n && dir == DIR_EXTEND)
      dir = DIR_STOP;

    r.extend     = (dir == DIR_EXTEND);
    r.retract    = (dir == DIR_RETRACT);
    r.led_user   = user_led;
    r.led_error  = error_led;
    r.led_homing = homing;
    r.position   = position;
    expected_outputs.push_back(r);
  endfunction

  function void compare_field(string name, int want, int got);
    if (got !== want) begin
      $error("%s expected %0d actual %0d", name, want, got);
      failures++;
    end
  endfunction

  function void check_result(pos_result_t got);
    pos_result_t want;
    if (expected_outputs.size() == 0) begin
      $error("result with no item outstanding, current_position %0d", $signed(got.position));
      failures++;
      return;
    end
    want = expected_outputs.pop_front();
    compare_field("extend_drive", int'(want.extend), int'(got.extend));
    compare_field("retract_drive", int'(want.retract), int'(got.retract));
    compare_field("led_user", int'(want.led_user), int'(got.led_user));
    compare_field("led_error", int'(want.led_error), int'(got.led_error));
    compare_field("led_homing", int'(want.led_homing), int'(got.led_homing));
    compare_field("current_position", int'($signed(want.position)),
                  int'($signed(got.position)));
  endfunction
endclass

module tb;
  localparam logic [1:0] OP_UNUSED       = 2'd3;
  localparam int         IDLE_PCT        = 33;
  localparam int         STALL_LIMIT     = 5000;
  localparam int         HOLD_OFF_AT     = 400;
  localparam int         HOLD_OFF_CYCLES = 200;
  localparam int         ITEMS_PER_PHASE = 280;
  localparam int         SWITCH_LOW_PCT  = 6;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [DEADBAND_BITS-1:0]       cfg_data;
  logic                           in_valid;
  logic                           in_ready;
  logic [1:0]                     op;
  logic [7:0]                     rx_byte;
  logic                           step_down;
  logic                           home_switch_n;
  logic                           limit_switch_n;
  logic                           out_valid;
  logic                           out_ready;
  logic                           extend_drive;
  logic                           retract_drive;
  logic                           led_user;
  logic                           led_error;
  logic                           led_homing;
  logic signed [OUT_POS_BITS-1:0] current_position;

  positioner_checker pos_model;
  bit                steady;
  int                results_taken;
  int                stall_cycles;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  serial_commanded_positioner_top u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .op               (op),
    .rx_byte          (rx_byte),
    .step_down        (step_down),
    .home_switch_n    (home_switch_n),
    .limit_switch_n   (limit_switch_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .extend_drive     (extend_drive),
    .retract_drive    (retract_drive),
    .led_user         (led_user),
    .led_error        (led_error),
    .led_homing       (led_homing),
    .current_position (current_position)
  );

  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic send_item(logic [1:0] code, logic [7:0] b, logic down, logic home_n,
                           logic limit_n);
    pos_item_t it;
    it = '{code, b, down, home_n, limit_n};
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    op             <= code;
    rx_byte        <= b;
    step_down      <= down;
    home_switch_n  <= home_n;
    limit_switch_n <= limit_n;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    pos_model.note_item(it);
  endtask

  task automatic send_plain(logic [1:0] code, logic [7:0] b);
    send_item(code, b, 1'b0, 1'b1, 1'b1);
  endtask

  function automatic logic switch_level();
    return ($urandom_range(0, 99) < SWITCH_LOW_PCT) ? 1'b0 : 1'b1;
  endfunction

  task automatic send_byte(logic [7:0] b);
    send_item(OP_BYTE, b, 1'($urandom_range(0, 1)), switch_level(), switch_level());
  endtask

  // Mostly values near zero so encoder steps cross the deadband.
  function automatic logic [15:0] pick_operand();
    int off;
    off = int'($urandom_range(0, 60)) - 30;
    case ($urandom_range(0, 9))
      0:       return 16'(32'h7FFF - $urandom_range(0, 20));
      1:       return 16'(32'h8000 + $urandom_range(0, 20));
      2, 3:    return 16'($urandom_range(0, 65535));
      default: return off[15:0];
    endcase
  endfunction

  // Occasionally breaks up an operand with an unrelated item.
  task automatic stray_item(inout int sent);
    if ($urandom_range(0, 99) < 8) begin
      send_item($urandom_range(0, 1) ? OP_STEP : OP_IDLE, 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)), switch_level(), switch_level());
      sent++;
    end
  endtask

  task automatic run_random(int count);
    int          sent;
    int          kind;
    int          burst;
    logic [7:0]  cmd;
    logic [15:0] value;
    logic        down;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        case ($urandom_range(0, 9))
          0, 1:    cmd = CMD_SET_TARGET;
          2, 3:    cmd = CMD_SET_POSITION;
          4:       cmd = CMD_HOME_START;
          5:       cmd = CMD_HOME_ABORT;
          6:       cmd = CMD_LED_ON;
          7:       cmd = CMD_LED_OFF;
          8:       cmd = CMD_OPERAND_FLAG | 8'($urandom_range(0, 127));
          default: cmd = 8'($urandom_range(0, 127));
        endcase
        send_byte(cmd);
        sent++;
        if ((cmd & CMD_OPERAND_FLAG) != CMD_NONE) begin
          value = pick_operand();
          stray_item(sent);
          send_byte(value[15:8]);
          stray_item(sent);
          send_byte(value[7:0]);
          sent += 2;
        end
      end else if (kind < 80) begin
        burst = $urandom_range(1, 12);
        down  = 1'($urandom_range(0, 1));
        repeat (burst) begin
          send_item(OP_STEP, 8'($urandom_range(0, 255)), down, switch_level(),
                    switch_level());
          sent++;
        end
      end else if (kind < 92) begin
        send_item($urandom_range(0, 3) == 0 ? OP_UNUSED : OP_IDLE,
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), switch_level(),
                  switch_level());
        sent++;
      end else begin
        send_byte(8'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  task automatic write_deadband(logic [DEADBAND_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    pos_model.set_deadband(value);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pos_model.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [DEADBAND_BITS-1:0] bands [0:5];
    int                       i;
    pos_model = new();
    steady    = 1'b0;
    rst            <= 1'b1;
    cfg_valid      <= 1'b0;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    op             <= OP_IDLE;
    rx_byte        <= 8'h00;
    step_down      <= 1'b0;
    home_switch_n  <= 1'b1;
    limit_switch_n <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, reset deadband
    send_plain(OP_IDLE, 8'h00);
    send_plain(OP_BYTE, CMD_NONE);
    send_plain(OP_BYTE, CMD_LED_ON);
    send_plain(OP_BYTE, 8'h7F);
    send_plain(OP_BYTE, CMD_LED_OFF);
    send_plain(OP_BYTE, CMD_SET_TARGET);
    send_plain(OP_BYTE, 8'h7F);
    send_item(OP_BYTE, 8'hFF, 1'b0, 1'b1, 1'b0);
    send_plain(OP_IDLE, 8'h00);
    send_plain(OP_BYTE, CMD_SET_POSITION);
    send_plain(OP_BYTE, 8'h7F);
    send_plain(OP_BYTE, 8'hFF);
    send_plain(OP_STEP, 8'h00);
    send_item(OP_STEP, 8'h00, 1'b1, 1'b1, 1'b1);
    send_plain(OP_BYTE, CMD_SET_TARGET);
    send_plain(OP_BYTE, 8'h80);
    send_plain(OP_BYTE, 8'h00);
    send_item(OP_IDLE, 8'h00, 1'b0, 1'b0, 1'b1);
    send_plain(OP_BYTE, 8'h81);
    send_plain(OP_BYTE, 8'h12);
    send_plain(OP_BYTE, 8'h34);
    send_plain(OP_BYTE, CMD_HOME_START);
    send_plain(OP_UNUSED, 8'hFF);
    send_plain(OP_BYTE, CMD_HOME_ABORT);
    send_plain(OP_BYTE, CMD_HOME_START);
    send_item(OP_IDLE, 8'h00, 1'b0, 1'b0, 1'b1);
    drain();

    bands[0] = '0;
    bands[1] = {DEADBAND_BITS{1'b1}};
    bands[2] = 15'd1;
    bands[3] = 15'($urandom_range(3, 40));
    bands[4] = 15'($urandom_range(0, 32767));
    bands[5] = DEADBAND_RESET;
    for (i = 0; i < 6; i++) begin
      write_deadband(bands[i]);
      steady = (i == 2);
      run_random(ITEMS_PER_PHASE);
      drain();
    end

    if (pos_model.failures == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Result side: random back-pressure plus one long hold-off so the input stalls.
  initial begin
    pos_result_t got;
    bit          held;
    held          = 1'b0;
    results_taken = 0;
    out_ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (!held && results_taken >= HOLD_OFF_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
      @(negedge clk);
      if (out_valid && out_ready) begin
        got = '{extend_drive, retract_drive, led_user, led_error, led_homing,
                current_position};
        pos_model.check_result(got);
        results_taken++;
      end
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(negedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("FAILURE");
    $finish;
  end
endmodule
